>>> sv/newton_fractal_cubic_root_finder_defines.svh
// ----------------------------------------------------------------------------
// Newton fractal root finder assertion macros
// Shared concurrent assertion forms for the root finder top level.
// ----------------------------------------------------------------------------
`ifndef NEWTON_FRACTAL_CUBIC_ROOT_FINDER_DEFINES_SVH
`define NEWTON_FRACTAL_CUBIC_ROOT_FINDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFCR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NFCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/nfcr_pkg.sv
// ----------------------------------------------------------------------------
// Newton fractal root finder package
// Constants, micro-operation codes, command and status types shared by the
// controller and the datapath, and the datapath's fixed-point helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcr_pkg;

   // Number formats.
   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS     = 28;
   localparam int MAX_ITER_BITS = 10;
   localparam int TOL_BITS      = 28;
   localparam int OPND_BITS     = WORD_BITS + 1;
   localparam int PROD_BITS     = 2 * OPND_BITS;
   localparam int WIDE_BITS     = PROD_BITS + 2;
   localparam int RND_BITS      = PROD_BITS - FRAC_BITS;
   localparam int CAP_SHIFT     = WORD_BITS - FRAC_BITS;
   localparam int CODE_BITS     = 12;

   // Register reset values.
   localparam logic [MAX_ITER_BITS-1:0] MAX_ITER_RESET = MAX_ITER_BITS'(30);
   localparam logic [TOL_BITS-1:0]      TOL_RESET      = TOL_BITS'(26844);

   // Root coordinates in fixed point.
   localparam logic signed [OPND_BITS-1:0] ONE_Q  = OPND_BITS'(268435456);
   localparam logic signed [OPND_BITS-1:0] HALF_Q = OPND_BITS'(134217728);
   localparam logic signed [OPND_BITS-1:0] SQ3H_Q = OPND_BITS'(232471924);

   // Sequencer program layout.
   localparam int SEQ_BITS = 5;
   localparam logic [SEQ_BITS-1:0] SEQ_TOL      = SEQ_BITS'(0);
   localparam logic [SEQ_BITS-1:0] SEQ_STEP     = SEQ_BITS'(1);
   localparam logic [SEQ_BITS-1:0] SEQ_STEP_END = SEQ_BITS'(16);
   localparam logic [SEQ_BITS-1:0] SEQ_DIST     = SEQ_BITS'(17);
   localparam logic [SEQ_BITS-1:0] SEQ_DIST_END = SEQ_BITS'(23);

   // Divider length: one quotient bit per cycle.
   localparam int DIV_CNT_BITS = 5;
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(WORD_BITS - 1);

   // Configuration register indexes.
   typedef enum logic {
      CSR_MAX_ITER  = 1'b0,
      CSR_TOLERANCE = 1'b1
   } csr_index_type;

   // Multiplier micro-operations.
   typedef enum logic [4:0] {
      MOP_NONE,
      MOP_TOL,
      MOP_Z2_RR,
      MOP_Z2_II,
      MOP_Z2_RI,
      MOP_Z3_RR,
      MOP_Z3_II,
      MOP_Z3_RI,
      MOP_Z3_IR,
      MOP_DEN_R,
      MOP_DEN_I,
      MOP_NRE_A,
      MOP_NRE_B,
      MOP_NIM_A,
      MOP_NIM_B,
      MOP_D0_R,
      MOP_D0_I,
      MOP_D1_R,
      MOP_D1_I,
      MOP_D2_R,
      MOP_D2_I
   } mop_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      mop_type mop;
      logic    z_load;
      logic    res_clear;
      logic    res_inc;
      logic    div_load;
      logic    div_step;
      logic    div_finish;
      logic    div_sel_im;
      logic    out_load;
      logic    out_conv;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic den_zero;
      logic hit;
      logic res_at_max;
   } status_type;

   // Sequencer program: multiplier operation at each program address.
   function automatic mop_type seq_mop(input logic [SEQ_BITS-1:0] addr);
      mop_type m;
      case (addr)
         5'd0:    m = MOP_TOL;
         5'd1:    m = MOP_Z2_RR;
         5'd2:    m = MOP_Z2_II;
         5'd3:    m = MOP_Z2_RI;
         5'd5:    m = MOP_Z3_RR;
         5'd6:    m = MOP_Z3_II;
         5'd7:    m = MOP_Z3_RI;
         5'd8:    m = MOP_Z3_IR;
         5'd10:   m = MOP_DEN_R;
         5'd11:   m = MOP_DEN_I;
         5'd12:   m = MOP_NRE_A;
         5'd13:   m = MOP_NRE_B;
         5'd14:   m = MOP_NIM_A;
         5'd15:   m = MOP_NIM_B;
         5'd17:   m = MOP_D0_R;
         5'd18:   m = MOP_D0_I;
         5'd19:   m = MOP_D1_R;
         5'd20:   m = MOP_D1_I;
         5'd21:   m = MOP_D2_R;
         5'd22:   m = MOP_D2_I;
         default: m = MOP_NONE;
      endcase
      return m;
   endfunction

   // Clamp a wide signed value to the signed word range.
   function automatic logic signed [WORD_BITS-1:0] sat32(input logic signed [WIDE_BITS-1:0] x);
      logic signed [WORD_BITS-1:0] r;
      if (x > WIDE_BITS'(64'sd2147483647)) begin
         r = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (x < -WIDE_BITS'(64'sd2147483648)) begin
         r = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         r = x[WORD_BITS-1:0];
      end
      return r;
   endfunction

   // Round a raw product to the fraction width, half up.
   function automatic logic signed [RND_BITS-1:0] round_q(input logic signed [PROD_BITS-1:0] p);
      logic signed [PROD_BITS:0] t;
      t = (PROD_BITS+1)'(p) + ((PROD_BITS+1)'(1) <<< (FRAC_BITS - 1));
      return t[PROD_BITS-1:FRAC_BITS];
   endfunction

endpackage

`default_nettype wire

>>> sv/nfcr_dpath.sv
// ----------------------------------------------------------------------------
// Newton fractal root finder datapath
// Shared multiplier with its accumulate stage, serial divider, distance
// registers, iteration counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcr_dpath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire nfcr_pkg::cmd_type                      cmd,
   output nfcr_pkg::status_type                        status,
   input  wire logic signed [nfcr_pkg::WORD_BITS-1:0]  start_real,
   input  wire logic signed [nfcr_pkg::WORD_BITS-1:0]  start_imag,
   input  wire logic [nfcr_pkg::MAX_ITER_BITS-1:0]     step_limit,
   input  wire logic [nfcr_pkg::TOL_BITS-1:0]          tolerance,
   output logic [nfcr_pkg::MAX_ITER_BITS-1:0]          iterations,
   output logic [1:0]                                  root_index,
   output logic                                        converged,
   output logic [nfcr_pkg::CODE_BITS-1:0]              pixel_code
);
   import nfcr_pkg::*;

   localparam int NUM_BITS  = PROD_BITS + 1;
   localparam int DIST_BITS = 64;

   // Working values.
   logic signed [WORD_BITS-1:0]  zr_ff, zi_ff, z2r_ff, z2i_ff, fr_ff, fi_ff;
   logic signed [RND_BITS-1:0]   t_ff;
   logic signed [PROD_BITS-1:0]  acc_ff, prod_ff;
   logic [DIST_BITS-1:0]         den_ff;
   logic signed [NUM_BITS-1:0]   nre_ff, nim_ff;
   logic [2*TOL_BITS-1:0]        tol2_ff;
   logic [DIST_BITS-1:0]         dist_ff [3];
   mop_type                      mop_ff;
   logic [MAX_ITER_BITS-1:0]     res_ff;

   // Divider state.
   logic [DIST_BITS-1:0]         rem_ff;
   logic [WORD_BITS-1:0]         nlo_ff, quo_ff;
   logic                         cap_ff, neg_ff;

   // Derivative 3 z^2.
   logic signed [WORD_BITS-1:0] fpr_w, fpi_w;
   assign fpr_w = sat32(WIDE_BITS'(z2r_ff) + WIDE_BITS'(z2r_ff) + WIDE_BITS'(z2r_ff));
   assign fpi_w = sat32(WIDE_BITS'(z2i_ff) + WIDE_BITS'(z2i_ff) + WIDE_BITS'(z2i_ff));

   // Coordinate differences to the three roots.
   logic signed [OPND_BITS-1:0] d0r_w, d1r_w, d1i_w, d2i_w;
   assign d0r_w = OPND_BITS'(zr_ff) - ONE_Q;
   assign d1r_w = OPND_BITS'(zr_ff) + HALF_Q;
   assign d1i_w = OPND_BITS'(zi_ff) - SQ3H_Q;
   assign d2i_w = OPND_BITS'(zi_ff) + SQ3H_Q;

   // Multiplier operand selection.
   logic signed [OPND_BITS-1:0] a_w, b_w;
   always_comb begin
      a_w = '0;
      b_w = '0;
      case (cmd.mop)
         MOP_TOL:   begin a_w = OPND_BITS'(tolerance); b_w = OPND_BITS'(tolerance); end
         MOP_Z2_RR: begin a_w = OPND_BITS'(zr_ff);  b_w = OPND_BITS'(zr_ff); end
         MOP_Z2_II: begin a_w = OPND_BITS'(zi_ff);  b_w = OPND_BITS'(zi_ff); end
         MOP_Z2_RI: begin a_w = OPND_BITS'(zr_ff);  b_w = OPND_BITS'(zi_ff); end
         MOP_Z3_RR: begin a_w = OPND_BITS'(z2r_ff); b_w = OPND_BITS'(zr_ff); end
         MOP_Z3_II: begin a_w = OPND_BITS'(z2i_ff); b_w = OPND_BITS'(zi_ff); end
         MOP_Z3_RI: begin a_w = OPND_BITS'(z2r_ff); b_w = OPND_BITS'(zi_ff); end
         MOP_Z3_IR: begin a_w = OPND_BITS'(z2i_ff); b_w = OPND_BITS'(zr_ff); end
         MOP_DEN_R: begin a_w = OPND_BITS'(fpr_w);  b_w = OPND_BITS'(fpr_w); end
         MOP_DEN_I: begin a_w = OPND_BITS'(fpi_w);  b_w = OPND_BITS'(fpi_w); end
         MOP_NRE_A: begin a_w = OPND_BITS'(fr_ff);  b_w = OPND_BITS'(fpr_w); end
         MOP_NRE_B: begin a_w = OPND_BITS'(fi_ff);  b_w = OPND_BITS'(fpi_w); end
         MOP_NIM_A: begin a_w = OPND_BITS'(fi_ff);  b_w = OPND_BITS'(fpr_w); end
         MOP_NIM_B: begin a_w = OPND_BITS'(fr_ff);  b_w = OPND_BITS'(fpi_w); end
         MOP_D0_R:  begin a_w = d0r_w; b_w = d0r_w; end
         MOP_D0_I:  begin a_w = OPND_BITS'(zi_ff); b_w = OPND_BITS'(zi_ff); end
         MOP_D1_R:  begin a_w = d1r_w; b_w = d1r_w; end
         MOP_D1_I:  begin a_w = d1i_w; b_w = d1i_w; end
         MOP_D2_R:  begin a_w = d1r_w; b_w = d1r_w; end
         MOP_D2_I:  begin a_w = d2i_w; b_w = d2i_w; end
         default:   begin a_w = '0; b_w = '0; end
      endcase
   end

   // Multiplier stage: product and the operation that made it.
   always_ff @(posedge clock) begin
      prod_ff <= a_w * b_w;
      if (reset) begin
         mop_ff <= MOP_NONE;
      end else begin
         mop_ff <= cmd.mop;
      end
   end

   // Accumulate stage values.
   logic signed [RND_BITS-1:0]  rq_w;
   logic signed [WORD_BITS-1:0] z3r_w;
   logic signed [WIDE_BITS-1:0] sum_w, diff_w;
   logic [DIST_BITS-1:0]        dsat_w;
   assign rq_w   = round_q(prod_ff);
   assign z3r_w  = sat32(WIDE_BITS'(t_ff) - WIDE_BITS'(rq_w));
   assign sum_w  = WIDE_BITS'(acc_ff) + WIDE_BITS'(prod_ff);
   assign diff_w = WIDE_BITS'(acc_ff) - WIDE_BITS'(prod_ff);
   assign dsat_w = (sum_w[WIDE_BITS-1:DIST_BITS] != '0) ? '1 : sum_w[DIST_BITS-1:0];

   // Consume the registered product.
   always_ff @(posedge clock) begin
      case (mop_ff)
         MOP_TOL:   tol2_ff <= prod_ff[2*TOL_BITS-1:0];
         MOP_Z2_RR: t_ff <= rq_w;
         MOP_Z2_II: z2r_ff <= sat32(WIDE_BITS'(t_ff) - WIDE_BITS'(rq_w));
         MOP_Z2_RI: z2i_ff <= sat32(WIDE_BITS'(rq_w) + WIDE_BITS'(rq_w));
         MOP_Z3_RR: t_ff <= rq_w;
         MOP_Z3_II: fr_ff <= sat32(WIDE_BITS'(z3r_w) - WIDE_BITS'(ONE_Q));
         MOP_Z3_RI: t_ff <= rq_w;
         MOP_Z3_IR: fi_ff <= sat32(WIDE_BITS'(t_ff) + WIDE_BITS'(rq_w));
         MOP_DEN_R, MOP_NRE_A, MOP_NIM_A, MOP_D0_R, MOP_D1_R, MOP_D2_R: acc_ff <= prod_ff;
         MOP_DEN_I: den_ff <= sum_w[DIST_BITS-1:0];
         MOP_NRE_B: nre_ff <= sum_w[NUM_BITS-1:0];
         MOP_NIM_B: nim_ff <= diff_w[NUM_BITS-1:0];
         MOP_D0_I:  dist_ff[0] <= dsat_w;
         MOP_D1_I:  dist_ff[1] <= dsat_w;
         MOP_D2_I:  dist_ff[2] <= dsat_w;
         default:   ;
      endcase
   end

   // Divider load values: magnitude and sign of the selected numerator.
   logic signed [NUM_BITS-1:0] num_w, mag_full_w;
   logic [DIST_BITS-1:0]       mag_w;
   logic [DIST_BITS:0]         r2_w, r2_sub_w;
   logic                       r2_ge_w;
   assign num_w      = cmd.div_sel_im ? nim_ff : nre_ff;
   assign mag_full_w = num_w[NUM_BITS-1] ? -num_w : num_w;
   assign mag_w      = mag_full_w[DIST_BITS-1:0];
   assign r2_w       = {rem_ff, nlo_ff[WORD_BITS-1]};
   assign r2_ge_w    = r2_w >= {1'b0, den_ff};
   assign r2_sub_w   = r2_w - {1'b0, den_ff};

   // Divider finish: capped, signed and saturated quotient, then z update.
   logic [WORD_BITS:0]           q_w;
   logic signed [WORD_BITS+1:0]  sq_w;
   logic signed [WORD_BITS-1:0]  qs_w, zsel_w, znew_w;
   assign q_w    = cap_ff ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, quo_ff};
   assign sq_w   = neg_ff ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});
   assign qs_w   = sat32(WIDE_BITS'(sq_w));
   assign zsel_w = cmd.div_sel_im ? zi_ff : zr_ff;
   assign znew_w = sat32(WIDE_BITS'(zsel_w) - WIDE_BITS'(qs_w));

   // Serial restoring divider, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         neg_ff <= num_w[NUM_BITS-1];
         cap_ff <= {{CAP_SHIFT{1'b0}}, mag_w} >= {den_ff, {CAP_SHIFT{1'b0}}};
         rem_ff <= mag_w >> CAP_SHIFT;
         nlo_ff <= {mag_w[CAP_SHIFT-1:0], {FRAC_BITS{1'b0}}};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= r2_ge_w ? r2_sub_w[DIST_BITS-1:0] : r2_w[DIST_BITS-1:0];
         quo_ff <= {quo_ff[WORD_BITS-2:0], r2_ge_w};
         nlo_ff <= {nlo_ff[WORD_BITS-2:0], 1'b0};
      end
   end

   // Current point: loaded from the transaction, updated by the divider.
   always_ff @(posedge clock) begin
      if (cmd.z_load) begin
         zr_ff <= start_real;
         zi_ff <= start_imag;
      end else if (cmd.div_finish) begin
         if (cmd.div_sel_im) begin
            zi_ff <= znew_w;
         end else begin
            zr_ff <= znew_w;
         end
      end
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else if (cmd.res_clear) begin
         res_ff <= '0;
      end else if (cmd.res_inc) begin
         res_ff <= res_ff + MAX_ITER_BITS'(1);
      end
   end

   // Root decisions: first root inside tolerance, and nearest root.
   logic       h0_w, h1_w, h2_w;
   logic [1:0] hit_root_w, near_root_w;
   logic [DIST_BITS-1:0] d01_w;
   assign h0_w = dist_ff[0] < DIST_BITS'(tol2_ff);
   assign h1_w = dist_ff[1] < DIST_BITS'(tol2_ff);
   assign h2_w = dist_ff[2] < DIST_BITS'(tol2_ff);
   assign hit_root_w = h0_w ? 2'd0 : (h1_w ? 2'd1 : 2'd2);
   assign d01_w = (dist_ff[1] < dist_ff[0]) ? dist_ff[1] : dist_ff[0];
   assign near_root_w = (dist_ff[2] < d01_w) ? 2'd2 :
                        ((dist_ff[1] < dist_ff[0]) ? 2'd1 : 2'd0);

   assign status.den_zero   = den_ff == '0;
   assign status.hit        = h0_w | h1_w | h2_w;
   assign status.res_at_max = res_ff >= step_limit;

   // Result register.
   logic [1:0] root_w;
   assign root_w = cmd.out_conv ? hit_root_w : near_root_w;
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         iterations <= res_ff;
         root_index <= root_w;
         converged  <= cmd.out_conv;
         pixel_code <= CODE_BITS'({res_ff, 1'b0}) + CODE_BITS'(res_ff) + CODE_BITS'(root_w);
      end
   end

endmodule

`default_nettype wire

>>> sv/nfcr_ctrl.sv
// ----------------------------------------------------------------------------
// Newton fractal root finder controller
// State machine that walks the multiply program, runs the two divisions of
// each step, tests for convergence and hands results to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output nfcr_pkg::cmd_type         cmd,
   input  wire nfcr_pkg::status_type status
);
   import nfcr_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SEQ    = 8'b0000_0010,
      S_DIVLD  = 8'b0000_0100,
      S_DIV    = 8'b0000_1000,
      S_DIVFIN = 8'b0001_0000,
      S_TEST   = 8'b0010_0000,
      S_CHECK  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic [SEQ_BITS-1:0]       seq_ff, seq_in;
   logic [DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                      im_ff, im_in;
   logic                      step_ff, step_in;
   logic                      conv_ff, conv_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      accept_w, out_free_w;

   assign accept_w   = req_valid & ~req_stall;
   assign out_free_w = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall  = state_ff != S_IDLE;
   assign rsp_valid  = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      seq_in   = seq_ff;
      cnt_in   = cnt_ff;
      im_in    = im_ff;
      step_in  = step_ff;
      conv_in  = conv_ff;
      cmd      = '0;
      cmd.mop  = MOP_NONE;
      cmd.div_sel_im = im_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept_w) begin
               cmd.z_load    = 1'b1;
               cmd.res_clear = 1'b1;
               seq_in        = SEQ_TOL;
               state_in      = S_SEQ;
            end
         end
         S_SEQ: begin
            cmd.mop = seq_mop(seq_ff);
            if (seq_ff == SEQ_TOL) begin
               // A zero step limit goes straight to the distance pass.
               step_in = ~status.res_at_max;
               seq_in  = status.res_at_max ? SEQ_DIST : SEQ_STEP;
            end else if (seq_ff == SEQ_STEP_END) begin
               if (status.den_zero) begin
                  seq_in = SEQ_DIST;
               end else begin
                  im_in    = 1'b0;
                  state_in = S_DIVLD;
               end
            end else if (seq_ff == SEQ_DIST_END) begin
               state_in = S_TEST;
            end else begin
               seq_in = seq_ff + SEQ_BITS'(1);
            end
         end
         S_DIVLD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = S_DIVFIN;
            end
         end
         S_DIVFIN: begin
            cmd.div_finish = 1'b1;
            if (!im_ff) begin
               im_in    = 1'b1;
               state_in = S_DIVLD;
            end else begin
               seq_in   = SEQ_DIST;
               state_in = S_SEQ;
            end
         end
         S_TEST: begin
            if (!step_ff) begin
               conv_in  = 1'b0;
               state_in = S_DONE;
            end else if (status.hit) begin
               conv_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.res_inc = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.res_at_max) begin
               conv_in  = 1'b0;
               state_in = S_DONE;
            end else begin
               seq_in   = SEQ_STEP;
               state_in = S_SEQ;
            end
         end
         S_DONE: begin
            cmd.out_conv = conv_ff;
            if (out_free_w) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output valid: set on load, cleared when the transaction is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seq_ff       <= '0;
         cnt_ff       <= '0;
         im_ff        <= 1'b0;
         step_ff      <= 1'b0;
         conv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         cnt_ff       <= cnt_in;
         im_ff        <= im_in;
         step_ff      <= step_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/newton_fractal_cubic_root_finder.sv
// ----------------------------------------------------------------------------
// Newton fractal root finder for z^3 - 1
// Iterates the Newton step from a Q4.28 start point and reports which cube
// root of unity it reaches, the step count and the combined pixel code.
//
//   Channel  Direction  Handshake            Contents
//   req      in         req_valid/req_stall  start_real, start_imag
//   rsp      out        rsp_valid/rsp_stall  iterations, root_index,
//                                            converged, pixel_code
//   csr      in/out     psel/penable/pready  step limit (0x0),
//                                            tolerance (0x4)
//
// One transaction is worked on at a time. A Newton step runs the product
// program on the shared 33x33 multiplier, two divisions in the serial divider
// and then the distance pass and test; a step with zero derivative skips the
// divisions. With a zero step limit only the distance pass runs before the
// result load.
// Synchronous reset, no clear.
// A finished result waits in the output register under rsp_stall while the
// next transaction is accepted and computed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "newton_fractal_cubic_root_finder_defines.svh"

module newton_fractal_cubic_root_finder (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [nfcr_pkg::WORD_BITS-1:0]  req_start_real,
   input  wire logic signed [nfcr_pkg::WORD_BITS-1:0]  req_start_imag,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [nfcr_pkg::MAX_ITER_BITS-1:0]          rsp_iterations,
   output logic [1:0]                                  rsp_root_index,
   output logic                                        rsp_converged,
   output logic [nfcr_pkg::CODE_BITS-1:0]              rsp_pixel_code,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [2:0]                             paddr,
   input  wire logic [31:0]                            pwdata,
   output logic [31:0]                                 prdata,
   output logic                                        pready
);
   import nfcr_pkg::*;

   logic [MAX_ITER_BITS-1:0] max_iter_ff;
   logic [TOL_BITS-1:0]      tol_ff;
   csr_index_type            csr_idx_w;
   cmd_type                  cmd;
   status_type               status;

   assign pready    = 1'b1;
   assign csr_idx_w = csr_index_type'(paddr[2]);

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
         tol_ff      <= TOL_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_idx_w)
            CSR_MAX_ITER:  max_iter_ff <= pwdata[MAX_ITER_BITS-1:0];
            CSR_TOLERANCE: tol_ff      <= pwdata[TOL_BITS-1:0];
            default:       ;
         endcase
      end
   end

   // Configuration register reads.
   always_comb begin
      unique case (csr_idx_w)
         CSR_MAX_ITER:  prdata = 32'(max_iter_ff);
         CSR_TOLERANCE: prdata = 32'(tol_ff);
         default:       prdata = '0;
      endcase
   end

   nfcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   nfcr_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .start_real     (req_start_real),
      .start_imag     (req_start_imag),
      .step_limit     (max_iter_ff),
      .tolerance      (tol_ff),
      .iterations     (rsp_iterations),
      .root_index     (rsp_root_index),
      .converged      (rsp_converged),
      .pixel_code     (rsp_pixel_code)
   );

   // The block is busy right after it takes a transaction.
   `NFCR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "not busy after accept")
   // The pixel code matches the step count and root of the same result.
   `NFCR_ASSERT_SAME(a_code_match, clock, reset, rsp_valid, (rsp_pixel_code == (CODE_BITS'({rsp_iterations, 1'b0}) + CODE_BITS'(rsp_iterations) + CODE_BITS'(rsp_root_index))), "pixel code mismatch")
   // A result that did not converge used up the whole step budget.
   `NFCR_ASSERT_SAME(a_limit_iter, clock, reset, rsp_valid && !rsp_converged, rsp_iterations == max_iter_ff, "unconverged result below step limit")

endmodule

`default_nettype wire

>>> bench/newton_fractal_cubic_root_finder_test.sv
// ----------------------------------------------------------------------------
// Newton fractal root finder testbench
// Sends complex start points through the request channel and compares every
// pixel result, field by field, with the typed result of its directed row
// or else with a bit-exact fixed-point Newton model kept here. The iteration
// limit and tolerance are changed between phases over APB with the block idle.
// ----------------------------------------------------------------------------
`default_nettype none

module newton_fractal_cubic_root_finder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import nfcr_pkg::*;

   localparam longint ONE_FX  = 64'sd268435456;
   localparam longint HALF_FX = 64'sd134217728;
   localparam longint SQ3H_FX = 64'sd232471924;
   localparam longint WMAX    = 64'sd2147483647;
   localparam longint WMIN    = -64'sd2147483648;

   typedef struct {
      longint re;
      longint im;
   } cplx_type;

   typedef struct packed {
      logic [9:0]  iter;
      logic [1:0]  root;
      logic        conv;
      logic [11:0] code;
   } pixel_type;

   typedef struct {
      longint    re;
      longint    im;
      bit        typed;
      pixel_type pix;
   } stim_row_type;

   typedef struct {
      bit        typed;
      pixel_type pix;
   } typed_entry_type;

   logic        clock = 1'b1;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic signed [31:0] req_start_real = '0;
   logic signed [31:0] req_start_imag = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [9:0]  rsp_iterations;
   logic [1:0]  rsp_root_index;
   logic        rsp_converged;
   logic [11:0] rsp_pixel_code;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Mirror of the configuration registers.
   int unsigned iter_limit = 30;
   logic [27:0] tol_cfg = 28'd26844;

   pixel_type       expected_pixels[$];
   typed_entry_type typed_pending[$];
   int     errors = 0;
   bit     no_idle = 1'b0;
   int     rsp_wait = 0;

   newton_fractal_cubic_root_finder i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_real(req_start_real), .req_start_imag(req_start_imag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_iterations(rsp_iterations), .rsp_root_index(rsp_root_index),
      .rsp_converged(rsp_converged), .rsp_pixel_code(rsp_pixel_code),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b0;
      #10 clock = 1'b1;
   end

   // Fixed-point arithmetic of the Newton step.
   function automatic longint clamp_word(longint x);
      if (x > WMAX) return WMAX;
      if (x < WMIN) return WMIN;
      return x;
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      longint p;
      p = a * b;
      return (p + HALF_FX) >>> FRAC_BITS;
   endfunction

   function automatic cplx_type cplx_mul(cplx_type a, cplx_type b);
      cplx_type r;
      r.re = clamp_word(fix_mul(a.re, b.re) - fix_mul(a.im, b.im));
      r.im = clamp_word(fix_mul(a.re, b.im) + fix_mul(a.im, b.re));
      return r;
   endfunction

   function automatic logic [63:0] mag_sum(longint p1, longint p2, output bit neg);
      logic [63:0] m1, m2;
      m1 = (p1 < 0) ? 64'(-p1) : 64'(p1);
      m2 = (p2 < 0) ? 64'(-p2) : 64'(p2);
      if ((p1 < 0) == (p2 < 0)) begin
         neg = (p1 < 0);
         return m1 + m2;
      end
      if (m1 >= m2) begin
         neg = (p1 < 0);
         return m1 - m2;
      end
      neg = (p2 < 0);
      return m2 - m1;
   endfunction

   // Quotient scaled to the fraction width, capped at 2^32, then clamped.
   function automatic longint scaled_quot(logic [63:0] n, bit neg, logic [63:0] d);
      logic [127:0] q;
      q = ({64'd0, n} << FRAC_BITS) / {64'd0, d};
      if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
      return clamp_word(neg ? -longint'(q[63:0]) : longint'(q[63:0]));
   endfunction

   function automatic cplx_type newton_update(cplx_type z);
      cplx_type z2, z3, f, fp, nz;
      logic [63:0] den, nre, nim;
      bit sre, sim;
      z2 = cplx_mul(z, z);
      z3 = cplx_mul(z2, z);
      f.re = clamp_word(z3.re - ONE_FX);
      f.im = z3.im;
      fp.re = clamp_word(3 * z2.re);
      fp.im = clamp_word(3 * z2.im);
      den = 64'(fp.re * fp.re) + 64'(fp.im * fp.im);
      // A zero derivative leaves the point where it is.
      if (den == 0) return z;
      nre = mag_sum(f.re * fp.re, f.im * fp.im, sre);
      nim = mag_sum(f.im * fp.re, -(f.re * fp.im), sim);
      nz.re = clamp_word(z.re - scaled_quot(nre, sre, den));
      nz.im = clamp_word(z.im - scaled_quot(nim, sim, den));
      return nz;
   endfunction

   function automatic logic [63:0] root_dist2(cplx_type z, longint rr, longint ri);
      longint dr, di;
      logic [63:0] mr, mi, a, b;
      logic [64:0] s;
      dr = z.re - rr;
      di = z.im - ri;
      mr = (dr < 0) ? 64'(-dr) : 64'(dr);
      mi = (di < 0) ? 64'(-di) : 64'(di);
      if (mr > 64'hFFFF_FFFF) mr = 64'hFFFF_FFFF;
      if (mi > 64'hFFFF_FFFF) mi = 64'hFFFF_FFFF;
      a = mr * mr;
      b = mi * mi;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // Expected pixel for one start point under the current settings.
   function automatic pixel_type predict_pixel(longint re, longint im);
      cplx_type z;
      logic [63:0] d[3];
      logic [63:0] tol2;
      int unsigned steps;
      int root;
      bit conv;
      pixel_type p;
      z.re = re;
      z.im = im;
      tol2 = 64'(tol_cfg) * 64'(tol_cfg);
      steps = 0;
      root = 0;
      conv = 1'b0;
      while (1) begin
         if (steps >= iter_limit) begin
            d[0] = root_dist2(z, ONE_FX, 0);
            d[1] = root_dist2(z, -HALF_FX, SQ3H_FX);
            d[2] = root_dist2(z, -HALF_FX, -SQ3H_FX);
            root = 0;
            if (d[1] < d[root]) root = 1;
            if (d[2] < d[root]) root = 2;
            break;
         end
         z = newton_update(z);
         d[0] = root_dist2(z, ONE_FX, 0);
         d[1] = root_dist2(z, -HALF_FX, SQ3H_FX);
         d[2] = root_dist2(z, -HALF_FX, -SQ3H_FX);
         if (d[0] < tol2) begin root = 0; conv = 1'b1; break; end
         if (d[1] < tol2) begin root = 1; conv = 1'b1; break; end
         if (d[2] < tol2) begin root = 2; conv = 1'b1; break; end
         steps++;
      end
      p.iter = steps[9:0];
      p.root = root[1:0];
      p.conv = conv;
      p.code = 12'(steps * 3 + root);
      return p;
   endfunction

   task automatic report(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // Predict or take the typed result on each accepted request, check each accepted result.
   always @(posedge clock) begin
      pixel_type want;
      typed_entry_type tp;
      if (!reset && req_valid && !req_stall) begin
         tp = typed_pending.pop_front();
         if (tp.typed) expected_pixels.push_back(tp.pix);
         else expected_pixels.push_back(predict_pixel(req_start_real, req_start_imag));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report("unexpected result", rsp_pixel_code, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_iterations !== want.iter) report("iterations", rsp_iterations, want.iter);
            if (rsp_root_index !== want.root) report("root_index", rsp_root_index, want.root);
            if (rsp_converged !== want.conv) report("converged", rsp_converged, want.conv);
            if (rsp_pixel_code !== want.code) report("pixel_code", rsp_pixel_code, want.code);
         end
      end
   end

   // Result side back-pressure: a random stall after each taken result, unless no_idle.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) rsp_wait = no_idle ? 0 : $urandom_range(0, 8);
      else if (rsp_wait > 0) rsp_wait--;
      rsp_stall <= (rsp_wait != 0);
   end

   task automatic send_point(longint re, longint im, bit typed, pixel_type pix);
      int gap;
      typed_entry_type tp;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      tp.typed = typed;
      tp.pix = pix;
      typed_pending.push_back(tp);
      req_valid <= 1'b1;
      req_start_real <= re[31:0];
      req_start_imag <= im[31:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Wait until every sent transaction has been accepted and answered.
   task automatic drain();
      req_valid <= 1'b0;
      while (typed_pending.size() != 0 || expected_pixels.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == CSR_MAX_ITER) iter_limit = val[9:0];
      else tol_cfg = val[27:0];
      @(posedge clock);
   endtask

   // Random start point: wide noise, points near a root, mid range, tiny, or on an axis.
   task automatic pick_point(output longint re, output longint im);
      int r;
      longint off_re, off_im;
      off_re = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
      off_im = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            re = longint'($signed($urandom));
            im = longint'($signed($urandom));
         end
         3, 4, 5: begin
            r = $urandom_range(0, 2);
            re = ((r == 0) ? ONE_FX : -HALF_FX) + off_re;
            im = ((r == 0) ? 64'sd0 : (r == 1) ? SQ3H_FX : -SQ3H_FX) + off_im;
         end
         6, 7: begin
            re = longint'($signed($urandom)) >>> 2;
            im = longint'($signed($urandom)) >>> 2;
         end
         8: begin
            re = longint'($urandom_range(0, 512)) - 256;
            im = longint'($urandom_range(0, 512)) - 256;
         end
         default: begin
            re = 0;
            im = longint'($signed($urandom));
            if ($urandom_range(0, 1)) begin
               re = im;
               im = 0;
            end
         end
      endcase
   endtask

   // Directed rows; typed results are the three exact roots.
   stim_row_type directed[] = '{
      '{ONE_FX, 0, 1'b1, '{10'd0, 2'd0, 1'b1, 12'd0}},
      '{-HALF_FX, SQ3H_FX, 1'b1, '{10'd0, 2'd1, 1'b1, 12'd1}},
      '{-HALF_FX, -SQ3H_FX, 1'b1, '{10'd0, 2'd2, 1'b1, 12'd2}},
      '{0, 0, 1'b0, '0},
      '{WMAX, WMAX, 1'b0, '0},
      '{WMIN, WMIN, 1'b0, '0},
      '{WMAX, WMIN, 1'b0, '0},
      '{WMIN, WMAX, 1'b0, '0},
      '{WMAX, 0, 1'b0, '0},
      '{0, WMIN, 1'b0, '0},
      '{WMIN, 0, 1'b0, '0},
      '{0, WMAX, 1'b0, '0},
      '{1, 0, 1'b0, '0},
      '{0, -1, 1'b0, '0},
      '{-1, -1, 1'b0, '0},
      '{-ONE_FX, 0, 1'b0, '0},
      '{0, ONE_FX, 1'b0, '0},
      '{ONE_FX + 26000, 0, 1'b0, '0},
      '{-HALF_FX, 0, 1'b0, '0},
      '{64'sh5555_5555, -64'sh2AAA_AAAA, 1'b0, '0}
   };

   initial begin
      int n_items, ph;
      longint re, im;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) send_point(directed[k].re, directed[k].im,
                                       directed[k].typed, directed[k].pix);
      drain();

      // Zero iteration limit: nearest root to the start point itself.
      csr_write(CSR_MAX_ITER, 32'd0);
      send_point(ONE_FX, 0, 1'b1, '{10'd0, 2'd0, 1'b0, 12'd0});
      send_point(-HALF_FX, -SQ3H_FX, 1'b1, '{10'd0, 2'd2, 1'b0, 12'd2});

      for (ph = 0; ph < 10; ph++) begin
         drain();
         n_items = 55;
         no_idle = 1'b0;
         case (ph)
            0: begin csr_write(CSR_MAX_ITER, 32'd0); csr_write(CSR_TOLERANCE, 32'd26844); end
            1: begin csr_write(CSR_MAX_ITER, 32'd1); csr_write(CSR_TOLERANCE, 32'd1); end
            2: begin
               csr_write(CSR_MAX_ITER, 32'd1023);
               csr_write(CSR_TOLERANCE, 32'h0FFF_FFFF);
               n_items = 20;
            end
            3: begin
               csr_write(CSR_MAX_ITER, 32'd20);
               csr_write(CSR_TOLERANCE, 32'd26844);
               no_idle = 1'b1;
            end
            4: begin csr_write(CSR_MAX_ITER, $urandom_range(2, 40)); csr_write(CSR_TOLERANCE, 32'd1); end
            5: begin
               csr_write(CSR_MAX_ITER, 32'hFFFF_FFFF);
               csr_write(CSR_TOLERANCE, 32'hF000_0001);
               n_items = 2;
            end
            default: begin
               csr_write(CSR_MAX_ITER, $urandom_range(2, 40));
               csr_write(CSR_TOLERANCE, $urandom_range(0, 1) ? $urandom_range(1, 1 << 20)
                                                           : $urandom_range(1, 28'h0FFF_FFFF));
            end
         endcase
         for (int i = 0; i < n_items; i++) begin
            // Let the block run dry once in the middle of a phase.
            if (ph == 6 && i == 20) begin
               drain();
            end
            pick_point(re, im);
            send_point(re, im, 1'b0, '0);
         end
      end
      drain();

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #400_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
